FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Request codes, status codes, field widths and the per-cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W      = 16;
    localparam int IN_PRIO_W = 8;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Move command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // place the new job, shift lower entries down one cell
        logic pop;   // shift every entry up one cell
    } cell_ctrl_t;

endpackage

FILE: rtl/core/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue as a chain of sorting cells
// Keeps jobs in descending priority, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat: req_type
//   selects insert, pop or clear; job_id and job_priority go with an insert.
//   Output channel (out_valid/out_ready) returns one result beat per request:
//   the head job after the operation (the popped job for a pop), a status
//   and the occupancy after the operation.
//   The result of an accepted request is registered and shows in the cycle after
//   it is accepted. Throughput is one request per cycle while out_ready is high;
//   the chain of QUEUE_DEPTH cells compares all entries against the new priority
//   in parallel and shifts them together, so the one-deep output register sets the rate.
//   A stalled receiver holds the result register; in_ready stays high only
//   while the result register is empty or being drained in the same cycle.
//   Reset empties the queue and drops any pending result. Stored entries are
//   not cleared; only cells below the occupancy count are ever read.
//   An insert into a full queue is dropped with status full; a pop of an
//   empty queue or a clear reports status empty with zero job fields.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH   = spq_pkg::DEF_QUEUE_DEPTH,
    parameter int PRIORITY_BITS = spq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spq_pkg::REQ_W-1:0]    req_type,
    input  logic [spq_pkg::ID_W-1:0]     job_id,
    input  logic [spq_pkg::IN_PRIO_W-1:0] job_priority,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [spq_pkg::ID_W-1:0]     head_id,
    output logic [spq_pkg::IN_PRIO_W-1:0] head_priority,
    output logic [spq_pkg::STATUS_W-1:0] status,
    output logic [spq_pkg::OCC_W-1:0]    occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Count register and result register
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [ID_W-1:0]      head_id_reg;
    logic [ID_W-1:0]      head_id_next;
    logic [IN_PRIO_W-1:0] head_prio_reg;
    logic [IN_PRIO_W-1:0] head_prio_next;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic [OCC_W-1:0]     occ_reg;

    logic accept;
    logic full;
    logic empty;
    cell_ctrl_t ctrl;

    logic [PRIORITY_BITS-1:0]           new_prio;
    logic [PRIORITY_BITS+IN_PRIO_W-1:0] new_prio_wide;
    logic [PRIORITY_BITS-1:0]           sel_prio;
    logic [PRIORITY_BITS+IN_PRIO_W-1:0] sel_prio_wide;
    logic [CNT_W+OCC_W-1:0]             count_wide;

    // Chain taps
    logic [QUEUE_DEPTH-1:0]     keep_vec;
    logic [ID_W-1:0]            cell_id   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0]   cell_prio [QUEUE_DEPTH];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    // Take the low PRIORITY_BITS of the request priority, zero-extend if wider
    assign new_prio_wide = (PRIORITY_BITS + IN_PRIO_W)'(job_priority);
    assign new_prio      = new_prio_wide[PRIORITY_BITS-1:0];

    // Broadcast the move: dropped inserts and empty pops leave the chain alone
    assign ctrl.ins = accept && (req_type == REQ_INSERT) && !full;
    assign ctrl.pop = accept && (req_type == REQ_POP) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            logic                     occ_c;
            logic                     left_keep_c;
            logic [ID_W-1:0]          left_id_c;
            logic [PRIORITY_BITS-1:0] left_prio_c;
            logic [ID_W-1:0]          right_id_c;
            logic [PRIORITY_BITS-1:0] right_prio_c;

            assign occ_c = (IDX < count_reg);

            if (gi == 0)
            begin : g_head
                // Nothing above the head: a non-kept head takes the new job
                assign left_keep_c = 1'b1;
                assign left_id_c   = job_id;
                assign left_prio_c = new_prio;
            end
            else
            begin : g_body
                assign left_keep_c = keep_vec[gi-1];
                assign left_id_c   = cell_id[gi-1];
                assign left_prio_c = cell_prio[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                // Tail slot becomes free on a pop; hold whatever it has
                assign right_id_c   = cell_id[gi];
                assign right_prio_c = cell_prio[gi];
            end
            else
            begin : g_mid
                assign right_id_c   = cell_id[gi+1];
                assign right_prio_c = cell_prio[gi+1];
            end

            spq_cell #(
                .PRIO_W (PRIORITY_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_id     (job_id),
                .new_prio   (new_prio),
                .occupied   (occ_c),
                .left_keep  (left_keep_c),
                .left_id    (left_id_c),
                .left_prio  (left_prio_c),
                .right_id   (right_id_c),
                .right_prio (right_prio_c),
                .keep       (keep_vec[gi]),
                .id         (cell_id[gi]),
                .prio       (cell_prio[gi])
            );
        end
    endgenerate

    // Occupancy after the operation
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (req_type)
                REQ_INSERT:
                begin
                    if (!full)
                        count_next = count_reg + CNT_W'(1);
                end
                REQ_POP:
                begin
                    if (!empty)
                        count_next = count_reg - CNT_W'(1);
                end
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Result beat: head after the operation, popped job for a pop
    always_comb
    begin
        head_id_next = '0;
        sel_prio     = '0;
        status_next  = ST_EMPTY;
        case (req_type)
            REQ_INSERT:
            begin
                if (full)
                begin
                    head_id_next = cell_id[0];
                    sel_prio     = cell_prio[0];
                    status_next  = ST_FULL;
                end
                else if (keep_vec[0])
                begin
                    head_id_next = cell_id[0];
                    sel_prio     = cell_prio[0];
                    status_next  = ST_OK;
                end
                else
                begin
                    head_id_next = job_id;
                    sel_prio     = new_prio;
                    status_next  = ST_OK;
                end
            end
            REQ_CLEAR:
            begin
                status_next = ST_EMPTY;
            end
            default:
            begin
                // Pop and the unused code both report the current head
                if (!empty)
                begin
                    head_id_next = cell_id[0];
                    sel_prio     = cell_prio[0];
                    status_next  = ST_OK;
                end
            end
        endcase
    end

    assign sel_prio_wide  = (PRIORITY_BITS + IN_PRIO_W)'(sel_prio);
    assign head_prio_next = sel_prio_wide[IN_PRIO_W-1:0];
    assign count_wide     = (CNT_W + OCC_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Load payload on accept, hold it while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_id_reg   <= head_id_next;
            head_prio_reg <= head_prio_next;
            status_reg    <= status_next;
            occ_reg       <= count_wide[OCC_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign head_id       = head_id_reg;
    assign head_priority = head_prio_reg;
    assign status        = status_reg;
    assign occupancy     = occ_reg;

    // Occupancy never runs past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy exceeds queue depth");

    // Stored entries stay sorted: kept cells form an unbroken run from the head
    a_keep_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((keep_vec >> 1) & ~keep_vec) == '0)
        else $error("cell chain out of priority order");

    // A clear leaves the queue empty
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_CLEAR) |=> (count_reg == '0))
        else $error("queue not empty after clear");

    // An empty status comes with zero job fields and zero occupancy
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |->
            (head_id_reg == '0 && head_prio_reg == '0 && occ_reg == '0))
        else $error("empty status with nonzero result fields");

endmodule

FILE: rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue chain
// Holds one job and either keeps it, takes the new job, or takes a neighbor's.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_W = 8
) (
    input  logic                     clk,
    input  spq_pkg::cell_ctrl_t      ctrl,
    input  logic [spq_pkg::ID_W-1:0] new_id,
    input  logic [PRIO_W-1:0]        new_prio,
    input  logic                     occupied,
    input  logic                     left_keep,
    input  logic [spq_pkg::ID_W-1:0] left_id,
    input  logic [PRIO_W-1:0]        left_prio,
    input  logic [spq_pkg::ID_W-1:0] right_id,
    input  logic [PRIO_W-1:0]        right_prio,
    output logic                     keep,
    output logic [spq_pkg::ID_W-1:0] id,
    output logic [PRIO_W-1:0]        prio
);
    import spq_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;

    // Entry stays ahead of a new job of equal or lower priority
    assign keep = occupied && (prio_reg >= new_prio);

    always_comb
    begin
        id_next   = id_reg;
        prio_next = prio_reg;
        if (ctrl.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    id_next   = new_id;
                    prio_next = new_prio;
                end
                else
                begin
                    id_next   = left_id;
                    prio_next = left_prio;
                end
            end
        end
        else if (ctrl.pop)
        begin
            id_next   = right_id;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule
